// ----- rtl/core/drs_pkg.sv -----
// ----------------------------------------------------------------------------
// drs_pkg
// Shared types and constants of the decimal radix sorter.
// ----------------------------------------------------------------------------
package drs_pkg;

   localparam int MaxItems  = 64;
   localparam int ValueBits = 16;
   localparam int IdxBits   = 6;
   localparam int CntBits   = 7;
   localparam int Radix     = 10;
   localparam int DigitBits = 4;

   typedef struct packed {
      logic [15:0] value;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [15:0] sorted_value;
      logic        last_out;
      logic        dropped;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_COUNT,
      ST_PREFIX,
      ST_SCATTER,
      ST_COPY,
      ST_NEXT,
      ST_EMIT,
      ST_WAIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // store the accepted request
      logic clear;      // zero the ten counters, reset the index
      logic count;      // count digit of entry at index
      logic prefix;     // one step of the prefix sum
      logic scatter;    // move one entry from the back into scratch
      logic copy;       // copy one entry from scratch back
      logic next_place; // advance the digit place
      logic emit;       // present entry at index on the output
      logic done;       // end of set: clear count, maximum, flag, place and index
      logic restart;    // reset the index only, counters untouched
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic step_last;  // current sweep is at its last step
      logic prefix_last;// prefix sum is at its last step
      logic more_digits;// maximum still has a digit at the place
      logic empty;      // no values stored
      logic emit_last;  // entry being emitted is the final one
   } sts_type;

endpackage

// ----- rtl/core/drs_datapath.sv -----
// ----------------------------------------------------------------------------
// drs_datapath
// Value store, scratch store, digit counters and the digit place register.
// ----------------------------------------------------------------------------
module drs_datapath (
   input  logic             clock,
   input  logic             reset,
   input  drs_pkg::req_type req_data,
   input  drs_pkg::cmd_type cmd,
   output drs_pkg::sts_type sts,
   output logic [15:0]      emit_value,
   output logic             emit_dropped
);

   logic [15:0] value_mem   [drs_pkg::MaxItems];
   logic [15:0] scratch_mem [drs_pkg::MaxItems];
   logic [drs_pkg::CntBits-1:0] cnt_ff [drs_pkg::Radix];

   logic [drs_pkg::CntBits-1:0] item_count_ff, item_count_in;
   logic [15:0]                 largest_ff, largest_in;
   logic                        overflow_ff, overflow_in;
   logic [drs_pkg::CntBits-1:0] idx_ff, idx_in;
   logic [drs_pkg::DigitBits-1:0] pidx_ff, pidx_in;
   logic [2:0]                  place_ff, place_in; // power of ten 0..4, reaching 5 after the place-4 pass
   logic [15:0]                 place_val;

   logic [drs_pkg::IdxBits-1:0] front_addr;
   logic [drs_pkg::IdxBits-1:0] back_addr;
   logic [drs_pkg::IdxBits-1:0] wr_addr;
   logic [15:0]                 front_ff;
   logic [15:0]                 back_ff;
   logic [15:0]                 scratch_ff;
   logic [15:0]                 sel_val;
   logic [15:0]                 quot_lo;
   logic [15:0]                 quot_hi;
   logic [drs_pkg::DigitBits-1:0] digit;
   logic [drs_pkg::CntBits-1:0] pos;

   always_comb begin
      unique case (place_ff)
         3'd0:    place_val = 16'd1;
         3'd1:    place_val = 16'd10;
         3'd2:    place_val = 16'd100;
         3'd3:    place_val = 16'd1000;
         default: place_val = 16'd10000;
      endcase
   end

   // The stores are read at the next index, so the read registers hold the
   // entry of the current index. Scatter walks from the back; the other
   // sweeps from the front.
   assign front_addr = idx_in[drs_pkg::IdxBits-1:0];
   assign back_addr  = drs_pkg::IdxBits'(item_count_ff - idx_in - 7'd1);
   assign sel_val    = cmd.scatter ? back_ff : front_ff;

   // Digit at a place: the quotients by the place and by ten times the place
   // come from reciprocal multiplications, exact for sixteen-bit values.
   always_comb begin
      unique case (place_ff)
         3'd0: begin
            quot_lo = sel_val;
            quot_hi = 16'((34'(sel_val) * 34'd52429) >> 19);
         end
         3'd1: begin
            quot_lo = 16'((34'(sel_val) * 34'd52429) >> 19);
            quot_hi = 16'((34'(sel_val) * 34'd83887) >> 23);
         end
         3'd2: begin
            quot_lo = 16'((34'(sel_val) * 34'd83887) >> 23);
            quot_hi = 16'((34'(sel_val) * 34'd67109) >> 26);
         end
         3'd3: begin
            quot_lo = 16'((34'(sel_val) * 34'd67109) >> 26);
            quot_hi = 16'((34'(sel_val) * 34'd107375) >> 30);
         end
         default: begin
            quot_lo = 16'((34'(sel_val) * 34'd107375) >> 30);
            quot_hi = 16'd0;
         end
      endcase
      digit = drs_pkg::DigitBits'(quot_lo - ((quot_hi << 3) + (quot_hi << 1)));
   end

   assign pos     = cnt_ff[digit] - 7'd1;
   assign wr_addr = pos[drs_pkg::IdxBits-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load && item_count_ff < 7'(drs_pkg::MaxItems))
         value_mem[item_count_ff[drs_pkg::IdxBits-1:0]] <= req_data.value;
      else if (cmd.copy)
         value_mem[idx_ff[drs_pkg::IdxBits-1:0]] <= scratch_ff;
      if (cmd.scatter)
         scratch_mem[wr_addr] <= back_ff;
      front_ff <= value_mem[front_addr];
      back_ff  <= value_mem[back_addr];
      // A scatter write to the entry being fetched is passed straight on.
      if (cmd.scatter && wr_addr == front_addr)
         scratch_ff <= back_ff;
      else
         scratch_ff <= scratch_mem[front_addr];
   end

   always_comb begin
      item_count_in = item_count_ff;
      largest_in    = largest_ff;
      overflow_in   = overflow_ff;
      idx_in        = idx_ff;
      pidx_in       = pidx_ff;
      place_in      = place_ff;
      if (cmd.load) begin
         if (item_count_ff < 7'(drs_pkg::MaxItems)) begin
            item_count_in = item_count_ff + 7'd1;
            if (req_data.value > largest_ff) largest_in = req_data.value;
         end else begin
            overflow_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         idx_in  = '0;
         pidx_in = 4'd1;
      end
      if (cmd.count || cmd.scatter || cmd.copy || cmd.emit) idx_in = idx_ff + 7'd1;
      if (cmd.restart) idx_in = '0;
      if (cmd.prefix) pidx_in = pidx_ff + 4'd1;
      if (cmd.next_place) place_in = place_ff + 3'd1;
      if (cmd.done) begin
         item_count_in = '0;
         largest_in    = '0;
         overflow_in   = 1'b0;
         place_in      = '0;
         idx_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         largest_ff    <= '0;
         overflow_ff   <= 1'b0;
         idx_ff        <= '0;
         pidx_ff       <= '0;
         place_ff      <= '0;
         for (int d = 0; d < drs_pkg::Radix; d++) cnt_ff[d] <= '0;
      end else begin
         item_count_ff <= item_count_in;
         largest_ff    <= largest_in;
         overflow_ff   <= overflow_in;
         idx_ff        <= idx_in;
         pidx_ff       <= pidx_in;
         place_ff      <= place_in;
         if (cmd.clear)
            for (int d = 0; d < drs_pkg::Radix; d++) cnt_ff[d] <= '0;
         else if (cmd.count)
            cnt_ff[digit] <= cnt_ff[digit] + 7'd1;
         else if (cmd.prefix)
            cnt_ff[pidx_ff] <= cnt_ff[pidx_ff] + cnt_ff[pidx_ff - 4'd1];
         else if (cmd.scatter)
            cnt_ff[digit] <= pos;
      end
   end

   always_comb begin
      sts.step_last   = (idx_ff + 7'd1 >= item_count_ff);
      sts.prefix_last = (pidx_ff == 4'(drs_pkg::Radix - 1));
      sts.more_digits = (place_ff <= 3'd4) && (largest_ff >= place_val);
      sts.empty       = (item_count_ff == '0);
      sts.emit_last   = (idx_ff + 7'd1 == item_count_ff);
   end

   assign emit_value   = front_ff;
   assign emit_dropped = overflow_ff;

endmodule

// ----- rtl/core/drs_control.sv -----
// ----------------------------------------------------------------------------
// drs_control
// Sequencer: load, per-digit passes, then emission.
// ----------------------------------------------------------------------------
module drs_control (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  logic             out_free,
   output logic             out_load,
   input  drs_pkg::sts_type sts,
   output drs_pkg::cmd_type cmd
);

   drs_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         drs_pkg::ST_LOAD:
            if (req_valid && req_last) state_in = drs_pkg::ST_NEXT;
         drs_pkg::ST_NEXT:
            if (sts.empty)            state_in = drs_pkg::ST_WAIT;
            else if (sts.more_digits) state_in = drs_pkg::ST_CLEAR;
            else                      state_in = drs_pkg::ST_EMIT;
         drs_pkg::ST_CLEAR:   state_in = drs_pkg::ST_COUNT;
         drs_pkg::ST_COUNT:
            if (sts.step_last) state_in = drs_pkg::ST_PREFIX;
         drs_pkg::ST_PREFIX:
            if (sts.prefix_last) state_in = drs_pkg::ST_SCATTER;
         drs_pkg::ST_SCATTER:
            if (sts.step_last) state_in = drs_pkg::ST_COPY;
         drs_pkg::ST_COPY:
            if (sts.step_last) state_in = drs_pkg::ST_NEXT;
         drs_pkg::ST_EMIT:
            if (out_free && sts.emit_last) state_in = drs_pkg::ST_WAIT;
         drs_pkg::ST_WAIT:    state_in = drs_pkg::ST_LOAD;
         default:             state_in = drs_pkg::ST_LOAD;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         drs_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         drs_pkg::ST_NEXT: begin
            // A fresh pass resets the index; leaving for emission does too.
            cmd.clear = 1'b1;
         end
         drs_pkg::ST_CLEAR:   cmd.clear   = 1'b1;
         drs_pkg::ST_COUNT:   cmd.count   = 1'b1;
         drs_pkg::ST_PREFIX:  cmd.prefix  = 1'b1;
         drs_pkg::ST_SCATTER: cmd.scatter = 1'b1;
         drs_pkg::ST_COPY: begin
            cmd.copy       = 1'b1;
            cmd.next_place = sts.step_last;
         end
         drs_pkg::ST_EMIT: begin
            cmd.emit = out_free;
            out_load = out_free;
         end
         drs_pkg::ST_WAIT:    cmd.done = 1'b1;
         default:             cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= drs_pkg::ST_LOAD;
      else       state_ff <= state_in;
   end

endmodule

// ----- rtl/core/drs_sweep_fix.sv -----
// ----------------------------------------------------------------------------
// drs_sweep_fix
// Index restart at the end of the count and scatter sweeps, merged into the
// controller's commands.
// ----------------------------------------------------------------------------
module drs_sweep_fix (
   input  drs_pkg::cmd_type cmd_raw,
   input  drs_pkg::sts_type sts,
   output drs_pkg::cmd_type cmd
);

   always_comb begin
      cmd = cmd_raw;
      // Restart the element index when a count or scatter sweep ends. The
      // counters must survive, so this only takes the index-reset path.
      cmd.restart = (cmd_raw.count || cmd_raw.scatter) && sts.step_last;
   end

endmodule

// ----- rtl/core/decimal_radix_sorter_core.sv -----
// ----------------------------------------------------------------------------
// decimal_radix_sorter_core
// LSD decimal radix sorter for up to 64 sixteen-bit values.
// ----------------------------------------------------------------------------
// Usage: values arrive one per request on the req_ channel (valid/ready) and
// are taken one per cycle while the block is loading. A request with
// is_last set closes the set. The block then runs one counting-sort pass per
// decimal digit of the largest stored value (at most five passes). A pass
// over N stored values runs a clear, a count sweep, a nine-step prefix sum,
// a scatter sweep from the back and a copy sweep. These sweeps over the
// stores, one entry per cycle, set the sort time.
// The sorted values then leave on the rsp_ channel in ascending order, one
// per cycle while the receiver takes them, the final one with last_out set;
// dropped marks every response of a set that lost values to a full store.
// Values beyond the 64th are discarded. A set of one empty store emits
// nothing. The response register holds its contents while the receiver
// stalls, and emission waits. No new request is accepted from is_last until
// the last response of the set has been registered. Reset clears the
// controller, the item count, the maximum, the flag and the output valid.
// ----------------------------------------------------------------------------
module decimal_radix_sorter_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  drs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output drs_pkg::rsp_type rsp_data
);

   drs_pkg::cmd_type cmd_raw, cmd;
   drs_pkg::sts_type sts;
   logic             out_free, out_load;
   logic [15:0]      emit_value;
   logic             emit_dropped;
   logic             rsp_valid_ff, rsp_valid_in;
   drs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // The output register can take a new value when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_ready;

   drs_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.is_last),
      .req_ready (req_ready),
      .out_free  (out_free),
      .out_load  (out_load),
      .sts       (sts),
      .cmd       (cmd_raw)
   );

   drs_sweep_fix u_fix (
      .cmd_raw (cmd_raw),
      .sts     (sts),
      .cmd     (cmd)
   );

   drs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .emit_value   (emit_value),
      .emit_dropped (emit_dropped)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.sorted_value  = emit_value;
         rsp_data_in.last_out      = sts.emit_last;
         rsp_data_in.dropped       = emit_dropped;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the decimal radix sorter: loads sets of values,
// predicts the ascending output of each set and compares every response.
// ----------------------------------------------------------------------------
module testbench;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   drs_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   drs_pkg::rsp_type rsp_data;

   decimal_radix_sorter_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // Sorter state as seen from outside.
   logic [15:0]      held_values[$];
   logic             lost_value;
   drs_pkg::rsp_type sorted_queue[$];

   int  error_count;
   int  request_total;
   int  response_total;
   int  send_idle_pct;
   int  take_stall_pct;
   bit  hold_receiver;

   // Builds the sorted result of the set held so far, then clears the set.
   task automatic close_set();
      logic [15:0]      ordered[$];
      drs_pkg::rsp_type r;
      ordered = held_values;
      ordered.sort();
      foreach (ordered[i]) begin
         r.sorted_value = ordered[i];
         r.last_out     = (i == ordered.size() - 1);
         r.dropped      = lost_value;
         sorted_queue.push_back(r);
      end
      held_values.delete();
      lost_value = 1'b0;
   endtask

   // Offers one request and waits for its acceptance, with random idle time.
   // Valid stays high on return so that requests can follow back to back.
   task automatic send_request(input logic [15:0] value, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_data.value   <= value;
      req_data.is_last <= is_last;
      do @(posedge clock); while (!req_ready);
      if (held_values.size() < drs_pkg::MaxItems) held_values.push_back(value);
      else lost_value = 1'b1;
      if (is_last) close_set();
      request_total++;
      @(negedge clock);
   endtask

   task automatic send_set(input int count, input int max_value);
      for (int i = 0; i < count; i++)
         send_request(16'($urandom_range(max_value)), i == count - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sorted_queue.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Receiver ready, with random stalls and an optional long hold.
   always @(negedge clock) begin
      if (reset || hold_receiver) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= take_stall_pct);
   end

   // Checks every accepted response against the oldest expectation.
   always @(posedge clock) begin
      drs_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         response_total++;
         if (sorted_queue.size() == 0) begin
            $error("unexpected response %h", rsp_data);
            error_count++;
         end else begin
            want = sorted_queue.pop_front();
            if (rsp_data.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d",
                      want.sorted_value, rsp_data.sorted_value);
               error_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out: expected %0b, got %0b", want.last_out, rsp_data.last_out);
               error_count++;
            end
            if (rsp_data.dropped !== want.dropped) begin
               $error("dropped: expected %0b, got %0b", want.dropped, rsp_data.dropped);
               error_count++;
            end
         end
      end
   end

   // Extremes of value, single-entry sets, equal values and every bit toggled.
   task automatic test_directed();
      send_request(16'hFFFF, 1'b1);
      send_request(16'h0000, 1'b1);
      send_request(16'hFFFF, 1'b0);
      send_request(16'h0000, 1'b0);
      send_request(16'h5555, 1'b0);
      send_request(16'hAAAA, 1'b0);
      send_request(16'd9, 1'b0);
      send_request(16'd10, 1'b0);
      send_request(16'd9, 1'b0);
      send_request(16'd65530, 1'b1);
      // Several passes with equal low digits test stability.
      send_request(16'd1234, 1'b0);
      send_request(16'd4234, 1'b0);
      send_request(16'd34, 1'b0);
      send_request(16'd99, 1'b1);
      wait_drained();
   endtask

   // A set larger than the store loses values and flags every response.
   task automatic test_store_full();
      send_set(70, 65535);
      send_set(64, 99);
      send_set(65, 9);
      wait_drained();
   endtask

   // Sets of random size and range under one idling mix.
   task automatic test_random_sets(input int idle_pct, input int stall_pct, input int sets);
      int range_pick;
      send_idle_pct  = idle_pct;
      take_stall_pct = stall_pct;
      for (int s = 0; s < sets; s++) begin
         range_pick = $urandom_range(3);
         send_set($urandom_range(1, 12),
                  range_pick == 0 ? 9 : range_pick == 1 ? 999 : 65535);
      end
      wait_drained();
   endtask

   // Receiver held off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct = 0;
      hold_receiver = 1'b1;
      fork
         begin
            repeat (400) @(negedge clock);
            hold_receiver = 1'b0;
         end
         begin
            send_set(20, 65535);
            send_set(10, 65535);
         end
      join
      wait_drained();
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      hold_receiver  = 1'b0;
      lost_value     = 1'b0;
      error_count    = 0;
      request_total  = 0;
      response_total = 0;
      send_idle_pct  = 0;
      take_stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_store_full();
      test_backpressure();
      test_random_sets(0, 0, 5);
      test_random_sets(52, 0, 5);
      test_random_sets(0, 52, 5);
      test_random_sets(38, 38, 5);
      repeat (200) @(negedge clock);

      $display("Sorted %0d requests into %0d responses: extremes, overflow sets,",
               request_total, response_total);
      $display("a long receiver hold and random sets under four idling mixes.");
      if (error_count == 0 && sorted_queue.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/drs_pkg.sv
rtl/core/drs_datapath.sv
rtl/core/drs_control.sv
rtl/core/drs_sweep_fix.sv
rtl/core/decimal_radix_sorter_core.sv
tb/testbench.sv
